/* design/asgr_pkg.sv */
// Package with the types, character codes and color map of the SGR color filter.
package asgr_pkg;

    localparam int unsigned C_DIGIT_W   = 4;
    localparam int unsigned C_MAX_DIGITS = 15;

    localparam logic [7:0] C_CHAR_NUL   = 8'h00;
    localparam logic [7:0] C_CHAR_ESC   = 8'h1B;
    localparam logic [7:0] C_CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] C_CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] C_CHAR_M     = 8'h6D;
    localparam logic [7:0] C_CHAR_ZERO  = 8'h30;
    localparam logic [7:0] C_CHAR_NINE  = 8'h39;

    localparam logic [7:0] C_CODE_SAT   = 8'd255;

    localparam logic [31:0] C_PEN_GREEN = 32'hFF00FF00;
    localparam logic [31:0] C_PEN_WHITE = 32'hFFFFFFFF;
    localparam logic [31:0] C_PEN_GRAY  = 32'hFF808080;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_ESC     = 2'd1,
        MODE_BRACKET = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0]  out_char;
        logic [31:0] pen_out;
        logic        end_mark;
    } t_result;

    // Packs channels as alpha, blue, green, red from the top byte down.
    function automatic logic [31:0] pack_rgba(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [7:0] a);
        return {a, b, g, r};
    endfunction

    function automatic logic [31:0] base_color(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0: c = pack_rgba(8'd0,   8'd0,   8'd0,   8'd255);
            3'd1: c = pack_rgba(8'd255, 8'd0,   8'd0,   8'd255);
            3'd2: c = pack_rgba(8'd0,   8'd255, 8'd0,   8'd255);
            3'd3: c = pack_rgba(8'd255, 8'd255, 8'd0,   8'd255);
            3'd4: c = pack_rgba(8'd0,   8'd0,   8'd255, 8'd255);
            3'd5: c = pack_rgba(8'd255, 8'd0,   8'd255, 8'd255);
            3'd6: c = pack_rgba(8'd0,   8'd255, 8'd255, 8'd255);
            default: c = pack_rgba(8'd255, 8'd255, 8'd255, 8'd255);
        endcase
        return c;
    endfunction

    function automatic logic [31:0] bright_color(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0: c = pack_rgba(8'd128, 8'd128, 8'd128, 8'd255);
            3'd1: c = pack_rgba(8'd255, 8'd128, 8'd128, 8'd255);
            3'd2: c = pack_rgba(8'd128, 8'd255, 8'd128, 8'd255);
            3'd3: c = pack_rgba(8'd255, 8'd255, 8'd128, 8'd255);
            3'd4: c = pack_rgba(8'd128, 8'd128, 8'd255, 8'd255);
            3'd5: c = pack_rgba(8'd255, 8'd128, 8'd255, 8'd255);
            3'd6: c = pack_rgba(8'd128, 8'd255, 8'd255, 8'd255);
            default: c = pack_rgba(8'd255, 8'd255, 8'd255, 8'd255);
        endcase
        return c;
    endfunction

    // Maps a closed SGR code to a pen color. Codes 40-47 and 100-107 act as 30-37.
    function automatic logic [31:0] map_code(input logic [7:0] code);
        logic [7:0]  d;
        logic [31:0] c;
        d = 8'd0;
        if (code >= 8'd30 && code <= 8'd37) begin
            d = code - 8'd30;
            c = base_color(d[2:0]);
        end else if (code >= 8'd90 && code <= 8'd97) begin
            d = code - 8'd90;
            c = bright_color(d[2:0]);
        end else if (code >= 8'd40 && code <= 8'd47) begin
            d = code - 8'd40;
            c = base_color(d[2:0]);
        end else if (code >= 8'd100 && code <= 8'd107) begin
            d = code - 8'd100;
            c = base_color(d[2:0]);
        end else if (code == 8'd1 || code == 8'd7) begin
            c = C_PEN_WHITE;
        end else if (code == 8'd2) begin
            c = C_PEN_GRAY;
        end else begin
            c = C_PEN_GREEN;
        end
        return c;
    endfunction

endpackage

/* design/asgr_in_if.sv */
// Input channel interface: one text byte per item.
interface asgr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

/* design/asgr_out_if.sv */
// Output channel interface: one filtered character with its pen color per item.
interface asgr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic [31:0] pen_out;
    logic        end_mark;

    modport source (output valid, output out_char, output pen_out, output end_mark,
                    input ready);
    modport sink   (input valid, input out_char, input pen_out, input end_mark,
                    output ready);
endinterface

/* design/asgr_out_reg.sv */
// Result register that holds one finished item until the downstream side takes it.
module asgr_out_reg
    import asgr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  t_result         i_result,
    output logic            o_ready,
    asgr_out_if.source      o_out
);

    logic    r_valid;
    t_result r_result;

    // The register can take a new item when empty or when it drains this cycle.
    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_char = r_result.out_char;
    assign o_out.pen_out  = r_result.pen_out;
    assign o_out.end_mark = r_result.end_mark;

endmodule

/* design/ansi_sgr_color_filter.sv */
// Top level of the SGR color filter: strips ESC [ ... m sequences and tags text with a pen color.
//
// The filter takes one text byte per item and sustains one item per clock cycle while the
// consumer keeps up. Bytes outside escape sequences come out unchanged, each tagged with the
// current pen color packed as alpha, blue, green, red from the most significant byte down; the pen
// resets to opaque green. The escape byte, the bytes of an ESC [ ... m sequence and any malformed
// sequence are consumed without a result item. Inside the brackets, decimal codes of up to fifteen
// digits (the value saturating at 255) close on a semicolon or on the final 'm' and set the pen
// color. A zero byte always produces a result item with end_mark set, returns the parser to plain
// text and keeps the pen. Each accepted byte updates the parser state in the same cycle and, when it
// yields a result, loads the single output register, so a result appears in the cycle after its
// byte is accepted. The input is ready whenever that output register is empty or is being taken
// in the same cycle, so a stalled consumer holds back the input by exactly one item.
module ansi_sgr_color_filter
    import asgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    asgr_in_if.sink     i_in,
    asgr_out_if.source  o_out
);

    t_mode                r_mode;
    t_mode                n_mode;
    logic [7:0]           r_code;
    logic [7:0]           n_code;
    logic [C_DIGIT_W-1:0] r_digits;
    logic [C_DIGIT_W-1:0] n_digits;
    logic [31:0]          r_pen;
    logic [31:0]          n_pen;

    logic       accept;
    logic       out_ready;
    logic       emit;
    t_result    result;
    logic [7:0] in_byte;
    logic       is_digit;
    logic [7:0] digit_val;
    logic [11:0] code_next;

    assign in_byte = i_in.text_byte;
    assign accept  = i_in.valid && out_ready;
    assign i_in.ready = out_ready;

    // Next decimal value of the pending code: value times ten plus the new digit.
    assign is_digit  = (in_byte >= C_CHAR_ZERO) && (in_byte <= C_CHAR_NINE);
    assign digit_val = in_byte - C_CHAR_ZERO;
    assign code_next = ({4'd0, r_code} << 3) + ({4'd0, r_code} << 1) + {4'd0, digit_val};

    // Parser state update and result selection for one accepted byte.
    always_comb begin
        n_mode   = r_mode;
        n_code   = r_code;
        n_digits = r_digits;
        n_pen    = r_pen;
        emit     = 1'b0;
        result.out_char = in_byte;
        result.pen_out  = r_pen;
        result.end_mark = 1'b0;

        if (in_byte == C_CHAR_NUL) begin
            // End of string: emit the terminator and reset the parser, keeping the pen.
            n_mode   = MODE_NORMAL;
            n_code   = 8'd0;
            n_digits = '0;
            emit     = 1'b1;
            result.end_mark = 1'b1;
        end else begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode = (in_byte == C_CHAR_LBRK) ? MODE_BRACKET : MODE_NORMAL;
                end
                MODE_BRACKET: begin
                    if (in_byte == C_CHAR_LBRK) begin
                        n_mode = MODE_BRACKET;
                    end else if (is_digit) begin
                        if (r_digits < C_DIGIT_W'(C_MAX_DIGITS)) begin
                            n_code   = (code_next > 12'd255) ? C_CODE_SAT : code_next[7:0];
                            n_digits = r_digits + 1'b1;
                        end
                    end else if (in_byte == C_CHAR_SEMI || in_byte == C_CHAR_M) begin
                        // A code closes only if it has at least one digit.
                        if (r_digits != '0) begin
                            n_pen = map_code(r_code);
                        end
                        n_code   = 8'd0;
                        n_digits = '0;
                        if (in_byte == C_CHAR_M) begin
                            n_mode = MODE_NORMAL;
                        end
                    end else begin
                        // Malformed sequence: drop the byte and the pending digits.
                        n_code   = 8'd0;
                        n_digits = '0;
                        n_mode   = MODE_NORMAL;
                    end
                end
                default: begin
                    // Plain text; the unused mode code behaves the same way.
                    if (in_byte == C_CHAR_ESC) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode = MODE_NORMAL;
                        emit   = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_code   <= 8'd0;
            r_digits <= '0;
            r_pen    <= C_PEN_GREEN;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_code   <= n_code;
            r_digits <= n_digits;
            r_pen    <= n_pen;
        end
    end

    asgr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && emit),
        .i_result (result),
        .o_ready  (out_ready),
        .o_out    (o_out)
    );

endmodule
